### hw/rtl/dgr_pkg.sv
package dgr_pkg;

    localparam int DEFAULT_MAP_SIDE = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int DIV_W      = 33;
    localparam int DIVISOR_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W    = 3'd6;

    localparam logic [21:0]        RST_PLAYER_X    = 22'd2129920;
    localparam logic [21:0]        RST_PLAYER_Y    = 22'd2129920;
    localparam logic signed [15:0] RST_VIEW_DIR_X  = 16'sd0;
    localparam logic signed [15:0] RST_VIEW_DIR_Y  = -16'sd16384;
    localparam logic signed [15:0] RST_CAM_PLANE_X = 16'sd10813;
    localparam logic signed [15:0] RST_CAM_PLANE_Y = 16'sd0;
    localparam logic [12:0]        RST_SCREEN_W    = 13'd640;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_CAST  = 1'b1;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_WALL  = 2'd1;
    localparam logic [1:0] CELL_DOOR  = 2'd2;

    localparam logic [1:0] SIDE_EAST  = 2'd0;
    localparam logic [1:0] SIDE_WEST  = 2'd1;
    localparam logic [1:0] SIDE_SOUTH = 2'd2;
    localparam logic [1:0] SIDE_NORTH = 2'd3;

    localparam logic [1:0] KIND_WALL  = 2'd0;
    localparam logic [1:0] KIND_DOOR  = 2'd1;
    localparam logic [1:0] KIND_BOUND = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CAM_GO,
        S_CAM_WAIT,
        S_MULX,
        S_MULY,
        S_RAYY,
        S_DX_GO,
        S_DX_WAIT,
        S_DY_GO,
        S_DY_WAIT,
        S_SIDEX,
        S_SIDEY,
        S_STEP,
        S_CHECK,
        S_FIN,
        S_DONE
    } state_t;

endpackage

### hw/rtl/dgr_div.sv
module dgr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dgr_pkg::DIV_W-1:0]     dividend,
    input  logic [dgr_pkg::DIVISOR_W-1:0] divisor,
    output logic                          done,
    output logic [dgr_pkg::DIV_W-1:0]     quotient
);
    import dgr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dsr_next = divisor;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/dda_grid_ray_caster.sv
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------------
// request  | in        | start high, busy low     | mode, cell_row, cell_col, cell_kind, column
// result   | out       | done strobe, one cycle   | hit_row, hit_col, hit_side, hit_kind,
//          |           |                          | wall_distance
// config   | in        | cfg_valid and cfg_ready  | cfg_index, cfg_data
//
// a map write takes effect at the accepting edge; busy stays low
// a cast runs up to 3 serial divisions (camera, x delta, y delta; a zero ray component skips
// its division), then a grid walk of at most 2*MAP_SIDE steps, each a step and a map read
// after reset busy stays high while all MAP_SIDE*MAP_SIDE map cells are cleared
// results cannot be held off; done is high for the single cycle that carries them
module dda_grid_ray_caster #(
    parameter int MAP_SIDE = dgr_pkg::DEFAULT_MAP_SIDE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           mode,
    input  logic [5:0]                     cell_row,
    input  logic [5:0]                     cell_col,
    input  logic [1:0]                     cell_kind,
    input  logic [11:0]                    column,
    output logic                           done,
    output logic [5:0]                     hit_row,
    output logic [5:0]                     hit_col,
    output logic [1:0]                     hit_side,
    output logic [1:0]                     hit_kind,
    output logic [23:0]                    wall_distance,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dgr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dgr_pkg::*;

    localparam int DEPTH      = MAP_SIDE * MAP_SIDE;
    localparam int DW         = $clog2(DEPTH);
    localparam int AW         = $clog2(MAP_SIDE);
    localparam int CW         = ((AW > 6) ? AW : 6) + 2;
    localparam int STEP_LIMIT = 2 * MAP_SIDE;
    localparam int SCW        = $clog2(STEP_LIMIT + 1);
    localparam int SDW        = 49;

    localparam logic signed [CW-1:0] SIDE_S = CW'(MAP_SIDE);
    localparam logic signed [CW-1:0] LAST_S = CW'(MAP_SIDE - 1);

    state_t state_reg, state_next;

    logic [21:0]        player_x_reg, player_y_reg;
    logic signed [15:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0] cam_plane_x_reg, cam_plane_y_reg;
    logic [12:0]        screen_w_reg;

    logic [11:0]          column_reg, column_next;
    logic signed [30:0]   cam_reg, cam_next;
    logic signed [46:0]   prod_reg, prod_next;
    logic signed [33:0]   rx_reg, rx_next, ry_reg, ry_next;
    logic [40:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic [SDW-1:0]       sx_reg, sx_next, sy_reg, sy_next;
    logic signed [CW-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [1:0]           side_reg, side_next;
    logic [1:0]           kind_reg, kind_next;
    logic [SCW-1:0]       steps_reg, steps_next;
    logic [DW-1:0]        clr_reg, clr_next;
    logic [5:0]           out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic [23:0]          dist_reg, dist_next;
    logic [1:0]           rd_reg;

    logic [1:0] map_mem [DEPTH];

    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend, div_quotient;
    logic [DIVISOR_W-1:0] div_divisor;

    logic                 accept, wr_ok, mem_we, rd_en;
    logic [DW-1:0]        mem_wa, rd_addr;
    logic [1:0]           mem_wd;
    logic                 rx_neg, ry_neg, rx_pos, ry_pos, step_x, oob;
    logic [33:0]          ray_mag;
    logic [12:0]          w_eff;
    logic signed [15:0]   plane_sel;
    logic [16:0]          f_sel;
    logic [40:0]          d_sel;
    logic [49:0]          side_prod;
    logic [SDW-1:0]       side_init, dist_full;
    logic signed [CW-1:0] mx_step, my_step;
    logic signed [CW-1:0] mx_clamp, my_clamp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign wr_ok     = (32'(cell_row) < MAP_SIDE) && (32'(cell_col) < MAP_SIDE);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_x_reg    <= RST_PLAYER_X;
            player_y_reg    <= RST_PLAYER_Y;
            view_dir_x_reg  <= RST_VIEW_DIR_X;
            view_dir_y_reg  <= RST_VIEW_DIR_Y;
            cam_plane_x_reg <= RST_CAM_PLANE_X;
            cam_plane_y_reg <= RST_CAM_PLANE_Y;
            screen_w_reg    <= RST_SCREEN_W;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PLAYER_X:    player_x_reg    <= cfg_data;
                CFG_PLAYER_Y:    player_y_reg    <= cfg_data;
                CFG_VIEW_DIR_X:  view_dir_x_reg  <= cfg_data[15:0];
                CFG_VIEW_DIR_Y:  view_dir_y_reg  <= cfg_data[15:0];
                CFG_CAM_PLANE_X: cam_plane_x_reg <= cfg_data[15:0];
                CFG_CAM_PLANE_Y: cam_plane_y_reg <= cfg_data[15:0];
                CFG_SCREEN_W:    screen_w_reg    <= cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    dgr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rx_neg = rx_reg[33];
    assign ry_neg = ry_reg[33];
    assign rx_pos = !rx_reg[33] && (rx_reg != '0);
    assign ry_pos = !ry_reg[33] && (ry_reg != '0);
    assign step_x = sx_reg < sy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    state_next = (clr_reg == DW'(DEPTH - 1)) ? S_IDLE : S_CLEAR;
            S_IDLE:     state_next = (accept && mode == MODE_CAST) ? S_CAM_GO : S_IDLE;
            S_CAM_GO:   state_next = S_CAM_WAIT;
            S_CAM_WAIT: state_next = div_done ? S_MULX : S_CAM_WAIT;
            S_MULX:     state_next = S_MULY;
            S_MULY:     state_next = S_RAYY;
            S_RAYY:     state_next = S_DX_GO;
            S_DX_GO:    state_next = (rx_reg == '0) ? S_DY_GO : S_DX_WAIT;
            S_DX_WAIT:  state_next = div_done ? S_DY_GO : S_DX_WAIT;
            S_DY_GO:    state_next = (ry_reg == '0) ? S_SIDEX : S_DY_WAIT;
            S_DY_WAIT:  state_next = div_done ? S_SIDEX : S_DY_WAIT;
            S_SIDEX:    state_next = S_SIDEY;
            S_SIDEY:    state_next = S_STEP;
            S_STEP:     state_next = oob ? S_FIN : S_CHECK;
            S_CHECK:
            begin
                if (rd_reg == CELL_WALL || rd_reg == CELL_DOOR
                    || steps_reg == SCW'(STEP_LIMIT))
                    state_next = S_FIN;
                else
                    state_next = S_STEP;
            end
            S_FIN:      state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        column_next  = column_reg;
        cam_next     = cam_reg;
        prod_next    = prod_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        side_next    = side_reg;
        kind_next    = kind_reg;
        steps_next   = steps_reg;
        clr_next     = clr_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        dist_next    = dist_reg;

        w_eff     = (screen_w_reg == '0) ? 13'd1 : screen_w_reg;
        ray_mag   = rx_neg ? 34'(-rx_reg) : 34'(rx_reg);
        div_start = 1'b0;
        div_dividend = {4'b0, column_reg, 17'b0};
        div_divisor  = 32'(w_eff);
        plane_sel = (state_reg == S_MULX) ? cam_plane_x_reg : cam_plane_y_reg;

        f_sel = (state_reg == S_SIDEX)
            ? (rx_neg ? {1'b0, player_x_reg[15:0]} : 17'd65536 - {1'b0, player_x_reg[15:0]})
            : (ry_neg ? {1'b0, player_y_reg[15:0]} : 17'd65536 - {1'b0, player_y_reg[15:0]});
        d_sel     = (state_reg == S_SIDEX) ? dx_reg : dy_reg;
        side_prod = f_sel * d_sel[32:0];
        side_init = d_sel[40] ? SDW'({f_sel, 24'b0}) : SDW'(side_prod >> 16);

        mx_step = mx_reg + (rx_neg ? -CW'(1) : CW'(1));
        my_step = my_reg + (ry_neg ? -CW'(1) : CW'(1));
        oob     = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;

        mem_we = 1'b0;
        mem_wa = DW'(32'(cell_row) * MAP_SIDE + 32'(cell_col));
        mem_wd = cell_kind;

        dist_full = (side_reg == SIDE_EAST || side_reg == SIDE_WEST)
            ? SDW'(sx_reg - SDW'(dx_reg)) : SDW'(sy_reg - SDW'(dy_reg));
        mx_clamp = (mx_reg < 0) ? '0 : ((mx_reg >= SIDE_S) ? LAST_S : mx_reg);
        my_clamp = (my_reg < 0) ? '0 : ((my_reg >= SIDE_S) ? LAST_S : my_reg);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = CELL_EMPTY;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                column_next = column;
                mem_we      = accept && (mode == MODE_WRITE) && wr_ok;
            end
            S_CAM_GO:
                div_start = 1'b1;
            S_CAM_WAIT:
                cam_next = $signed({1'b0, div_quotient[29:0]}) - 31'sd65536;
            S_MULX:
                prod_next = plane_sel * cam_reg;
            S_MULY:
            begin
                rx_next   = (34'(view_dir_x_reg) <<< 2) + 34'(prod_reg >>> 14);
                prod_next = plane_sel * cam_reg;
            end
            S_RAYY:
                ry_next = (34'(view_dir_y_reg) <<< 2) + 34'(prod_reg >>> 14);
            S_DX_GO:
            begin
                div_dividend = {1'b1, 32'b0};
                div_divisor  = ray_mag[31:0];
                div_start    = (rx_reg != '0);
                dx_next      = {1'b1, 40'b0};
            end
            S_DX_WAIT:
                dx_next = 41'(div_quotient);
            S_DY_GO:
            begin
                div_dividend = {1'b1, 32'b0};
                div_divisor  = ry_neg ? 32'(-ry_reg) : 32'(ry_reg);
                div_start    = (ry_reg != '0);
                dy_next      = {1'b1, 40'b0};
            end
            S_DY_WAIT:
                dy_next = 41'(div_quotient);
            S_SIDEX:
            begin
                sx_next    = side_init;
                mx_next    = CW'(player_x_reg[21:16]);
                my_next    = CW'(player_y_reg[21:16]);
                steps_next = '0;
            end
            S_SIDEY:
                sy_next = side_init;
            S_STEP:
            begin
                steps_next = steps_reg + 1'b1;
                if (step_x)
                begin
                    sx_next   = sx_reg + SDW'(dx_reg);
                    mx_next   = mx_step;
                    side_next = rx_pos ? SIDE_EAST : SIDE_WEST;
                    oob       = (mx_step < 0) || (mx_step >= SIDE_S)
                                || (my_reg < 0) || (my_reg >= SIDE_S);
                    rd_addr   = DW'(32'(unsigned'(my_reg)) * MAP_SIDE
                                + 32'(unsigned'(mx_step)));
                end
                else
                begin
                    sy_next   = sy_reg + SDW'(dy_reg);
                    my_next   = my_step;
                    side_next = ry_pos ? SIDE_SOUTH : SIDE_NORTH;
                    oob       = (my_step < 0) || (my_step >= SIDE_S)
                                || (mx_reg < 0) || (mx_reg >= SIDE_S);
                    rd_addr   = DW'(32'(unsigned'(my_step)) * MAP_SIDE
                                + 32'(unsigned'(mx_reg)));
                end
                rd_en     = !oob;
                kind_next = KIND_BOUND;
            end
            S_CHECK:
            begin
                case (rd_reg)
                    CELL_WALL: kind_next = KIND_WALL;
                    CELL_DOOR: kind_next = KIND_DOOR;
                    default:   kind_next = KIND_BOUND;
                endcase
            end
            S_FIN:
            begin
                out_row_next = my_clamp[5:0];
                out_col_next = mx_clamp[5:0];
                dist_next    = (dist_full[SDW-1:24] != '0) ? 24'hFFFFFF : dist_full[23:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        column_reg  <= column_next;
        cam_reg     <= cam_next;
        prod_reg    <= prod_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        side_reg    <= side_next;
        kind_reg    <= kind_next;
        steps_reg   <= steps_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        dist_reg    <= dist_next;
    end

    // map store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_wa] <= mem_wd;
        if (rd_en)
            rd_reg <= map_mem[rd_addr];
    end

    assign done          = (state_reg == S_DONE);
    assign hit_row       = out_row_reg;
    assign hit_col       = out_col_reg;
    assign hit_side      = side_reg;
    assign hit_kind      = kind_reg;
    assign wall_distance = dist_reg;

endmodule

### hw/rtl/dgr_checker.sv
module dgr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       mode,
    input logic       done,
    input logic [1:0] hit_kind
);
    import dgr_pkg::*;

    // a result only appears while a cast is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside a cast");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_CAST) |=> busy)
        else $error("cast request did not start a walk");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_WRITE) |=> (!busy && !done))
        else $error("map write caused activity");

    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_kind == KIND_WALL || hit_kind == KIND_DOOR
                  || hit_kind == KIND_BOUND))
        else $error("bad hit kind");

endmodule

bind dda_grid_ray_caster dgr_checker u_dgr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .done     (done),
    .hit_kind (hit_kind)
);
